### design/svf_pkg.sv
// shared types, widths and saturation helpers for the state variable filter
// used by every module of the filter core; depends on nothing
package svf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int FREQ_W   = 18;
  localparam int DAMP_W   = 21;
  localparam int FRAC_W   = 16;
  localparam int COEF_W   = (FREQ_W > DAMP_W) ? FREQ_W : DAMP_W;
  localparam int PROD_W   = STATE_W + COEF_W + 1;
  localparam int SH_W     = PROD_W - FRAC_W;
  localparam int SUM_W    = SH_W + 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [DAMP_W-1:0] DAMPING_RESET = DAMP_W'(65536);

  localparam logic signed [SUM_W-1:0] STATE_MAX =
    {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] STATE_MIN =
    {{(SUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
  localparam logic signed [STATE_W-1:0] SAMPLE_MAX =
    {{(STATE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] SAMPLE_MIN =
    {{(STATE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_FREQ_COEF = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_SCALE     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_XD,
    ST_MUL_BF,
    ST_MUL_BD,
    ST_HIGH,
    ST_MUL_HF,
    ST_BAND
  } state_t;

  typedef enum logic [1:0] {
    MUL_XD,
    MUL_BF,
    MUL_BD,
    MUL_HF
  } mul_sel_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_coef;
    logic [DAMP_W-1:0] damping;
    logic              scale_by_damping;
  } cfg_t;

  typedef struct packed {
    logic     load_x;
    mul_sel_t mul_sel;
    logic     load_xs;
    logic     load_low;
    logic     load_high;
    logic     load_band;
  } cmd_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > STATE_MAX) r = STATE_MAX[STATE_W-1:0];
    else if (v < STATE_MIN) r = STATE_MIN[STATE_W-1:0];
    else r = v[STATE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [STATE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAMPLE_MAX) r = SAMPLE_MAX[SAMPLE_W-1:0];
    else if (v < SAMPLE_MIN) r = SAMPLE_MIN[SAMPLE_W-1:0];
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

endpackage

### design/state_variable_filter_core.sv
// top level of the resonant state variable filter core
// an accepted item steps through MUL_XD, MUL_BF, MUL_BD, HIGH, MUL_HF and BAND before
// out_valid; no new item is taken until idle, as the single shared multiplier forms
// all four coefficient products in turn; the output register holds a result while
// the next item is taken and processed; reset (synchronous, active high) zeroes both
// delay states, loads freq_coef 0, damping 1.0 and scaling off, and clears out_valid
module state_variable_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [svf_pkg::SAMPLE_W-1:0] low_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0] high_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0] band_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [svf_pkg::ADDR_W-1:0]          paddr,
  input  logic [svf_pkg::DATA_W-1:0]          pwdata,
  output logic [svf_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  svf_pkg::cfg_t cfg;
  svf_pkg::cmd_t cmd;

  svf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  svf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .sample   (sample),
    .low_out  (low_out),
    .high_out (high_out),
    .band_out (band_out)
  );

endmodule

### design/svf_regs.sv
// apb configuration registers: frequency coefficient, damping, input scaling flag
// depends on svf_pkg
module svf_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svf_pkg::ADDR_W-1:0]   paddr,
  input  logic [svf_pkg::DATA_W-1:0]   pwdata,
  output logic [svf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output svf_pkg::cfg_t                cfg
);

  svf_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = svf_pkg::reg_idx_t'(paddr[svf_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_coef        <= '0;
      cfg.damping          <= svf_pkg::DAMPING_RESET;
      cfg.scale_by_damping <= 1'b0;
    end else if (wr) begin
      case (idx)
        svf_pkg::REG_FREQ_COEF: cfg.freq_coef <= pwdata[svf_pkg::FREQ_W-1:0];
        svf_pkg::REG_DAMPING:   cfg.damping   <= pwdata[svf_pkg::DAMP_W-1:0];
        svf_pkg::REG_SCALE:     cfg.scale_by_damping <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      svf_pkg::REG_FREQ_COEF: prdata = svf_pkg::DATA_W'(cfg.freq_coef);
      svf_pkg::REG_DAMPING:   prdata = svf_pkg::DATA_W'(cfg.damping);
      svf_pkg::REG_SCALE:     prdata = svf_pkg::DATA_W'(cfg.scale_by_damping);
      default:                prdata = '0;
    endcase
  end

endmodule

### design/svf_datapath.sv
// filter datapath: one shared coefficient multiplier, adders with saturation,
// the band and low delay states and the output registers; depends on svf_pkg
module svf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  svf_pkg::cmd_t                      cmd,
  input  svf_pkg::cfg_t                      cfg,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] sample,
  output logic signed [svf_pkg::SAMPLE_W-1:0] low_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0] high_out,
  output logic signed [svf_pkg::SAMPLE_W-1:0] band_out
);

  logic signed [svf_pkg::SAMPLE_W-1:0] x;
  logic signed [svf_pkg::STATE_W-1:0]  xs, low, high;
  logic signed [svf_pkg::STATE_W-1:0]  band_delay, low_delay;
  logic signed [svf_pkg::SH_W-1:0]     prod;

  logic signed [svf_pkg::STATE_W-1:0]  mul_a;
  logic        [svf_pkg::COEF_W-1:0]   mul_c;
  logic signed [svf_pkg::PROD_W-1:0]   mul_p;
  logic signed [svf_pkg::STATE_W-1:0]  xs_next, low_next, high_next, band_next;

  always_comb begin
    case (cmd.mul_sel)
      svf_pkg::MUL_XD: begin
        mul_a = svf_pkg::STATE_W'(x);
        mul_c = svf_pkg::COEF_W'(cfg.damping);
      end
      svf_pkg::MUL_BF: begin
        mul_a = band_delay;
        mul_c = svf_pkg::COEF_W'(cfg.freq_coef);
      end
      svf_pkg::MUL_BD: begin
        mul_a = band_delay;
        mul_c = svf_pkg::COEF_W'(cfg.damping);
      end
      svf_pkg::MUL_HF: begin
        mul_a = high;
        mul_c = svf_pkg::COEF_W'(cfg.freq_coef);
      end
      default: begin
        mul_a = band_delay;
        mul_c = svf_pkg::COEF_W'(cfg.freq_coef);
      end
    endcase
    // exact signed x unsigned product
    mul_p = svf_pkg::PROD_W'(mul_a) * svf_pkg::PROD_W'($signed({1'b0, mul_c}));
  end

  always_comb begin
    if (cfg.scale_by_damping) xs_next = svf_pkg::sat_state(svf_pkg::SUM_W'(prod));
    else xs_next = svf_pkg::STATE_W'(x);
    low_next  = svf_pkg::sat_state(svf_pkg::SUM_W'(low_delay) + svf_pkg::SUM_W'(prod));
    high_next = svf_pkg::sat_state(svf_pkg::SUM_W'(xs) - svf_pkg::SUM_W'(low)
                                   - svf_pkg::SUM_W'(prod));
    band_next = svf_pkg::sat_state(svf_pkg::SUM_W'(prod) + svf_pkg::SUM_W'(band_delay));
  end

  // dropping the low fraction bits of the signed product floors it
  always_ff @(posedge clk) begin
    prod <= mul_p[svf_pkg::PROD_W-1:svf_pkg::FRAC_W];
    if (cmd.load_x) x <= sample;
    if (cmd.load_xs) xs <= xs_next;
    if (cmd.load_low) low <= low_next;
    if (cmd.load_high) high <= high_next;
    if (cmd.load_band) begin
      low_out  <= svf_pkg::sat_sample(low);
      high_out <= svf_pkg::sat_sample(high);
      band_out <= svf_pkg::sat_sample(band_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_delay <= '0;
      low_delay  <= '0;
    end else if (cmd.load_band) begin
      band_delay <= band_next;
      low_delay  <= low;
    end
  end

endmodule

### design/svf_ctrl.sv
// sequencer for the filter: steps the shared multiplier through its four products
// and owns the input stall and output valid; depends on svf_pkg
module svf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output svf_pkg::cmd_t cmd
);

  svf_pkg::state_t state, state_next;
  logic            slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != svf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= svf_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd.load_x    = 1'b0;
    cmd.mul_sel   = svf_pkg::MUL_XD;
    cmd.load_xs   = 1'b0;
    cmd.load_low  = 1'b0;
    cmd.load_high = 1'b0;
    cmd.load_band = 1'b0;
    case (state)
      svf_pkg::ST_IDLE: begin
        cmd.load_x = in_valid;
        if (in_valid) state_next = svf_pkg::ST_MUL_XD;
      end
      svf_pkg::ST_MUL_XD: begin
        cmd.mul_sel = svf_pkg::MUL_XD;
        state_next  = svf_pkg::ST_MUL_BF;
      end
      svf_pkg::ST_MUL_BF: begin
        cmd.load_xs = 1'b1;
        cmd.mul_sel = svf_pkg::MUL_BF;
        state_next  = svf_pkg::ST_MUL_BD;
      end
      svf_pkg::ST_MUL_BD: begin
        cmd.load_low = 1'b1;
        cmd.mul_sel  = svf_pkg::MUL_BD;
        state_next   = svf_pkg::ST_HIGH;
      end
      svf_pkg::ST_HIGH: begin
        cmd.load_high = 1'b1;
        state_next    = svf_pkg::ST_MUL_HF;
      end
      svf_pkg::ST_MUL_HF: begin
        cmd.mul_sel = svf_pkg::MUL_HF;
        state_next  = svf_pkg::ST_BAND;
      end
      svf_pkg::ST_BAND: begin
        // hold the finished item until the output register is free
        cmd.mul_sel   = svf_pkg::MUL_HF;
        cmd.load_band = slot_free;
        if (slot_free) state_next = svf_pkg::ST_IDLE;
      end
      default: state_next = svf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_band) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == svf_pkg::ST_MUL_XD))
    else $error("accepted item did not start the multiply sequence");

  a_band_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_band |=> out_valid)
    else $error("finished item not presented at the output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_band |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");

  a_band_waits: assert property (@(posedge clk) disable iff (rst)
    (state == svf_pkg::ST_BAND && out_valid && out_stall) |=> (state == svf_pkg::ST_BAND))
    else $error("sequencer left the final step while the output was blocked");

endmodule
